// ----- hdl/dsp_pkg.sv -----
`timescale 1ns / 1ps
package dsp_pkg;

   localparam int SLOTS = 16;
   localparam int IDX_W = 4;
   localparam int CNT_W = 5;
   localparam int DIV_STEPS = 48;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam logic [31:0] EPS_RAW     = 32'd6;
   localparam logic [31:0] DUR_MIN_RAW = 32'd66;
   localparam logic [31:0] ONE_RAW     = 32'h0001_0000;
   localparam logic [31:0] FPS_DIV     = 32'd60;
   localparam logic [31:0] TENTH_DIV   = 32'd10;
   localparam logic [31:0] M32         = 32'hFFFF_FFFF;

   // x / 60 == (x * RECIP_60) >> 37 and x / 10 == (x * RECIP_10) >> 35 for 32-bit x
   localparam logic [31:0] RECIP_60    = 32'h8888_8889;
   localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;

   localparam logic KIND_SRC    = 1'b0;
   localparam logic KIND_STATUS = 1'b1;
   localparam logic MODE_TICK   = 1'b0;
   localparam logic MODE_SPAWN  = 1'b1;

   typedef enum logic [2:0] {
      ST_TICK   = 3'd0,
      ST_APPEND = 3'd1,
      ST_EVICT  = 3'd2,
      ST_DROP   = 3'd3,
      ST_WEAK   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_T_RD, S_T_LD, S_T_RDIV, S_T_RM1, S_T_RM2, S_T_ST, S_T_SDIV,
      S_T_SM1, S_T_SM2, S_T_EMIT, S_T_END, S_SC_RD, S_SC_LD, S_SC_DEC, S_SP_DIV
   } fsm_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] strength;
      logic [31:0] radius;
      logic [31:0] speed;
      logic [31:0] life;
      logic [31:0] elapsed;
   } entry_type;

   typedef struct packed {
      logic               mode;
      logic [31:0]        dt;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [31:0]        strength;
      logic [31:0]        max_radius;
      logic [31:0]        grow_speed;
      logic [31:0]        life_time;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] src_x;
      logic signed [31:0] src_y;
      logic [31:0]        src_radius;
      logic [31:0]        src_strength;
      logic [2:0]         status_code;
      logic [6:0]         active_count;
      logic [31:0]        drop_total;
      logic [31:0]        evict_total;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [47:0] num;
      logic [31:0] den;
   } div_req_type;

endpackage

// ----- hdl/dsp_mem.sv -----
`timescale 1ns / 1ps
module dsp_mem (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [dsp_pkg::IDX_W-1:0]          wr_addr,
   input  dsp_pkg::entry_type                 wr_data,
   input  logic [dsp_pkg::IDX_W-1:0]          rd_addr,
   output dsp_pkg::entry_type                 rd_data
);

   dsp_pkg::entry_type mem_ff [dsp_pkg::SLOTS];
   dsp_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/dsp_div.sv -----
`timescale 1ns / 1ps
module dsp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  dsp_pkg::div_req_type div_req,
   output logic                 done,
   output logic [47:0]          quot
);

   logic [31:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[47]};
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.num;
         den_in  = div_req.den;
         cnt_in  = 6'(dsp_pkg::DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 32'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ----- hdl/distortion_source_pool_core.sv -----
`timescale 1ns / 1ps
// Pool of up to 16 distortion sources in arrival order; an evicting spawn takes the evicted slot.
// req channel: one transaction per item, mode 0 = tick by dt, mode 1 = spawn.
// rsp channel: zero or more source records (kind 0) followed by one status
// record (kind 1, last 1) per item. One item is in flight at a time.
// A new item is taken only while the core is idle; the status record of the
// previous item may still sit in the output register at that time.
// Spawn: a weak spawn is rejected with its status record only; an appended
// spawn writes its slot, forms the initial radius by reciprocal multiply and
// returns one source record. With a full pool every slot is scanned, each by
// a read and a load state; a drop then returns its status only, an eviction
// overwrites the weakest slot (oldest on a tie) and goes on like an append.
// Tick: an expiring slot is read and dropped; any other also runs the radius
// and strength steps, with up to two waits on the shared bit-serial divider.
// Slot state lives in one synchronous memory, read one slot at a time.
// A stalled rsp holds the output register and the sequencer waits for it
// before it puts a new record into that register.
// Synchronous reset empties the pool and clears both counters; slot contents
// are not cleared.
module distortion_source_pool_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dsp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dsp_pkg::rsp_type rsp_data
);

   dsp_pkg::fsm_type    state_ff, state_in;
   dsp_pkg::req_type    req_ff, req_in;
   dsp_pkg::status_type status_ff, status_in;
   dsp_pkg::entry_type  ent_ff, ent_in;
   dsp_pkg::entry_type  rd_data, wr_data;
   dsp_pkg::rsp_type    out_ff, out_in;
   dsp_pkg::div_req_type div_req;
   logic                out_valid_ff, out_valid_in;
   logic [dsp_pkg::IDX_W-1:0] idx_ff, idx_in, slot_ff, slot_in, best_ff, best_in;
   logic [dsp_pkg::IDX_W-1:0] wr_addr, last_idx;
   logic [dsp_pkg::CNT_W-1:0] live_ff, live_in, w_ff, w_in;
   logic [31:0] drop_ff, drop_in, evict_ff, evict_in;
   logic [31:0] rad_ff, rad_in, str_ff, str_in;
   logic [31:0] best_str_ff, best_str_in, best_el_ff, best_el_in;
   logic [31:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [63:0] prod_ff;
   logic [31:0] mulq, enew, dur, prog, r0;
   logic [32:0] esum;
   logic [47:0] quot;
   logic        div_done, wr_en, out_free, faint;

   dsp_mem u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   dsp_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .done   (div_done),
      .quot   (quot)
   );

   assign out_free = !out_valid_ff || !rsp_stall;
   assign mulq     = (prod_ff[63:48] != 16'd0) ? dsp_pkg::M32 : prod_ff[47:16];
   assign esum     = {1'b0, rd_data.elapsed} + {1'b0, req_ff.dt};
   assign enew     = esum[32] ? dsp_pkg::M32 : esum[31:0];
   assign dur      = (rd_data.life > dsp_pkg::DUR_MIN_RAW) ? rd_data.life
                                                           : dsp_pkg::DUR_MIN_RAW;
   assign prog     = (quot[47:16] != 32'd0) ? dsp_pkg::ONE_RAW : quot[31:0];
   assign last_idx = dsp_pkg::idx_type'(live_ff - dsp_pkg::cnt_type'(1));
   assign faint    = (req_data.strength <= dsp_pkg::EPS_RAW) ||
                     ((req_data.max_radius <= dsp_pkg::EPS_RAW) &&
                      (req_data.grow_speed <= dsp_pkg::EPS_RAW));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      status_in    = status_ff;
      ent_in       = ent_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      best_in      = best_ff;
      live_in      = live_ff;
      w_in         = w_ff;
      drop_in      = drop_ff;
      evict_in     = evict_ff;
      rad_in       = rad_ff;
      str_in       = str_ff;
      best_str_in  = best_str_ff;
      best_el_in   = best_el_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      div_req      = '0;
      wr_en        = 1'b0;
      wr_addr      = w_ff[dsp_pkg::IDX_W-1:0];
      wr_data      = ent_ff;
      r0           = '0;
      req_stall    = 1'b1;
      unique case (state_ff)
         dsp_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in = req_data;
               idx_in = '0;
               w_in   = '0;
               if (req_data.mode == dsp_pkg::MODE_TICK) begin
                  status_in = dsp_pkg::ST_TICK;
                  state_in  = (live_ff == '0) ? dsp_pkg::S_T_END : dsp_pkg::S_T_RD;
               end else if (faint) begin
                  status_in = dsp_pkg::ST_WEAK;
                  state_in  = dsp_pkg::S_T_END;
                  w_in      = live_ff;
               end else if (live_ff == dsp_pkg::cnt_type'(dsp_pkg::SLOTS)) begin
                  state_in = dsp_pkg::S_SC_RD;
               end else begin
                  status_in = dsp_pkg::ST_APPEND;
                  slot_in   = live_ff[dsp_pkg::IDX_W-1:0];
                  live_in   = live_ff + dsp_pkg::cnt_type'(1);
                  state_in  = dsp_pkg::S_SC_DEC;
               end
            end
         end
         dsp_pkg::S_T_RD: begin
            state_in = dsp_pkg::S_T_LD;
         end
         dsp_pkg::S_T_LD: begin
            ent_in         = rd_data;
            ent_in.elapsed = enew;
            if ((rd_data.life != 32'd0) && (enew >= rd_data.life)) begin
               idx_in   = idx_ff + dsp_pkg::idx_type'(1);
               state_in = (idx_ff == last_idx) ? dsp_pkg::S_T_END : dsp_pkg::S_T_RD;
            end else if (rd_data.speed > dsp_pkg::EPS_RAW) begin
               mul_a_in = rd_data.speed;
               mul_b_in = enew;
               state_in = dsp_pkg::S_T_RM1;
            end else if (enew >= dur) begin
               mul_a_in = rd_data.radius;
               mul_b_in = dsp_pkg::ONE_RAW;
               state_in = dsp_pkg::S_T_RM1;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = {enew, 16'd0};
               div_req.den   = dur;
               state_in      = dsp_pkg::S_T_RDIV;
            end
         end
         dsp_pkg::S_T_RDIV: begin
            if (div_done) begin
               mul_a_in = ent_ff.radius;
               mul_b_in = prog;
               state_in = dsp_pkg::S_T_RM1;
            end
         end
         dsp_pkg::S_T_RM1: begin
            state_in = dsp_pkg::S_T_RM2;
         end
         dsp_pkg::S_T_RM2: begin
            rad_in = mulq;
            if ((ent_ff.speed > dsp_pkg::EPS_RAW) && (ent_ff.radius > dsp_pkg::EPS_RAW) &&
                (mulq > ent_ff.radius)) begin
               rad_in = ent_ff.radius;
            end
            state_in = dsp_pkg::S_T_ST;
         end
         dsp_pkg::S_T_ST: begin
            if (ent_ff.life <= dsp_pkg::EPS_RAW) begin
               str_in   = ent_ff.strength;
               state_in = dsp_pkg::S_T_EMIT;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = {ent_ff.elapsed, 16'd0};
               div_req.den   = ent_ff.life;
               state_in      = dsp_pkg::S_T_SDIV;
            end
         end
         dsp_pkg::S_T_SDIV: begin
            if (div_done) begin
               mul_a_in = ent_ff.strength;
               mul_b_in = dsp_pkg::ONE_RAW - prog;
               state_in = dsp_pkg::S_T_SM1;
            end
         end
         dsp_pkg::S_T_SM1: begin
            state_in = dsp_pkg::S_T_SM2;
         end
         dsp_pkg::S_T_SM2: begin
            str_in   = mulq;
            state_in = dsp_pkg::S_T_EMIT;
         end
         dsp_pkg::S_T_EMIT: begin
            if (out_free || (rad_ff <= dsp_pkg::EPS_RAW) || (str_ff <= dsp_pkg::EPS_RAW)) begin
               if ((rad_ff > dsp_pkg::EPS_RAW) && (str_ff > dsp_pkg::EPS_RAW)) begin
                  out_in              = '0;
                  out_in.kind         = dsp_pkg::KIND_SRC;
                  out_in.src_x        = signed'(ent_ff.x);
                  out_in.src_y        = signed'(ent_ff.y);
                  out_in.src_radius   = rad_ff;
                  out_in.src_strength = str_ff;
                  out_valid_in        = 1'b1;
               end
               wr_en    = 1'b1;
               wr_addr  = w_ff[dsp_pkg::IDX_W-1:0];
               wr_data  = ent_ff;
               w_in     = w_ff + dsp_pkg::cnt_type'(1);
               idx_in   = idx_ff + dsp_pkg::idx_type'(1);
               state_in = (idx_ff == last_idx) ? dsp_pkg::S_T_END : dsp_pkg::S_T_RD;
            end
         end
         dsp_pkg::S_T_END: begin
            if (out_free) begin
               if (status_ff == dsp_pkg::ST_TICK) begin
                  live_in = w_ff;
               end
               out_in              = '0;
               out_in.kind         = dsp_pkg::KIND_STATUS;
               out_in.status_code  = status_ff;
               out_in.active_count = 7'(live_in);
               out_in.drop_total   = drop_ff;
               out_in.evict_total  = evict_ff;
               out_in.last         = 1'b1;
               out_valid_in        = 1'b1;
               state_in            = dsp_pkg::S_IDLE;
            end
         end
         dsp_pkg::S_SC_RD: begin
            state_in = dsp_pkg::S_SC_LD;
         end
         dsp_pkg::S_SC_LD: begin
            if ((idx_ff == '0) || (rd_data.strength < best_str_ff) ||
                ((rd_data.strength == best_str_ff) && (rd_data.elapsed > best_el_ff))) begin
               best_in     = idx_ff;
               best_str_in = rd_data.strength;
               best_el_in  = rd_data.elapsed;
            end
            idx_in = idx_ff + dsp_pkg::idx_type'(1);
            if (idx_ff == last_idx) begin
               state_in = dsp_pkg::S_SC_DEC;
               if (req_ff.strength > best_str_in) begin
                  slot_in   = best_in;
                  status_in = dsp_pkg::ST_EVICT;
                  evict_in  = (evict_ff == dsp_pkg::M32) ? evict_ff : evict_ff + 32'd1;
               end else begin
                  status_in = dsp_pkg::ST_DROP;
                  drop_in   = (drop_ff == dsp_pkg::M32) ? drop_ff : drop_ff + 32'd1;
                  w_in      = live_ff;
                  state_in  = dsp_pkg::S_T_END;
               end
            end else begin
               state_in = dsp_pkg::S_SC_RD;
            end
         end
         dsp_pkg::S_SC_DEC: begin
            wr_en            = 1'b1;
            wr_addr          = slot_ff;
            wr_data.x        = unsigned'(req_ff.pos_x);
            wr_data.y        = unsigned'(req_ff.pos_y);
            wr_data.strength = req_ff.strength;
            wr_data.radius   = req_ff.max_radius;
            wr_data.speed    = req_ff.grow_speed;
            wr_data.life     = req_ff.life_time;
            wr_data.elapsed  = '0;
            if (req_ff.grow_speed > dsp_pkg::EPS_RAW) begin
               mul_a_in = req_ff.grow_speed;
               mul_b_in = dsp_pkg::RECIP_60;
            end else begin
               mul_a_in = req_ff.max_radius;
               mul_b_in = dsp_pkg::RECIP_10;
            end
            idx_in   = '0;
            w_in     = live_ff;
            state_in = dsp_pkg::S_SP_DIV;
         end
         dsp_pkg::S_SP_DIV: begin
            // first cycle waits for the product register
            if (req_ff.grow_speed > dsp_pkg::EPS_RAW) begin
               r0 = {5'd0, prod_ff[63:37]};
               if (req_ff.max_radius < r0) begin
                  r0 = req_ff.max_radius;
               end
            end else begin
               r0 = {3'd0, prod_ff[63:35]};
            end
            if (r0 < dsp_pkg::ONE_RAW) begin
               r0 = dsp_pkg::ONE_RAW;
            end
            if (idx_ff == '0) begin
               idx_in = dsp_pkg::idx_type'(1);
            end else if (out_free) begin
               out_in              = '0;
               out_in.kind         = dsp_pkg::KIND_SRC;
               out_in.src_x        = req_ff.pos_x;
               out_in.src_y        = req_ff.pos_y;
               out_in.src_radius   = r0;
               out_in.src_strength = req_ff.strength;
               out_valid_in        = 1'b1;
               idx_in              = '0;
               state_in            = dsp_pkg::S_T_END;
            end
         end
         default: begin
            state_in = dsp_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsp_pkg::S_IDLE;
         out_valid_ff <= 1'b0;
         live_ff      <= '0;
         drop_ff      <= '0;
         evict_ff     <= '0;
         idx_ff       <= '0;
         rad_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         live_ff      <= live_in;
         drop_ff      <= drop_in;
         evict_ff     <= evict_in;
         idx_ff       <= idx_in;
         rad_ff       <= rad_in;
      end
      req_ff      <= req_in;
      status_ff   <= status_in;
      ent_ff      <= ent_in;
      out_ff      <= out_in;
      slot_ff     <= slot_in;
      best_ff     <= best_in;
      w_ff        <= w_in;
      str_ff      <= str_in;
      best_str_ff <= best_str_in;
      best_el_ff  <= best_el_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      prod_ff     <= mul_a_ff * mul_b_ff;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- hdl/dsp_chk.sv -----
`timescale 1ns / 1ps
module dsp_chk (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dsp_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == rsp_data.kind))
      else $error("last flag does not match record kind");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind |-> rsp_data.active_count <= 7'(dsp_pkg::SLOTS))
      else $error("active count above pool size");

   a_src_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.kind |-> rsp_data.status_code == 3'd0 &&
                                      rsp_data.active_count == 7'd0)
      else $error("source record carries status fields");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind distortion_source_pool_core dsp_chk u_dsp_chk (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
